// File: sv/dpc_pkg.sv
// Shared types, field widths and cell kind codes for the degenerate polygon collapse block.
// Used by the load, collapse and top-level modules; depends on nothing else.

package dpc_pkg;

  // Field widths of the stream items.
  localparam int NODE_W      = 31;
  localparam int KIND_W      = 3;
  localparam int COUNT_W     = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Node counts travel between modules at the width of the largest supported cell.
  localparam int CNT_W = 7;

  // Cell kind codes.
  localparam logic [KIND_W-1:0] KIND_TRI   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUAD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POLY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRI6  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUAD8 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_QPOLY = 3'd5;

  // Node counts that select a retyped kind.
  localparam logic [CNT_W-1:0] NODES_TRI   = 7'd3;
  localparam logic [CNT_W-1:0] NODES_QUAD  = 7'd4;
  localparam logic [CNT_W-1:0] NODES_TRI6  = 7'd6;
  localparam logic [CNT_W-1:0] NODES_QUAD8 = 7'd8;

  // Handoff of a fully loaded cell from the load side to the collapse side.
  typedef struct packed {
    logic              start;
    logic              dup;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  n;
  } handoff_t;

  // Status of the collapse side as seen by the top level.
  typedef struct packed {
    logic active;
    logic done;
  } col_status_t;

  // True for the quadratic kinds, whose second half holds mid-edge nodes.
  function automatic logic is_quadratic(input logic [KIND_W-1:0] kind);
    return (kind == KIND_TRI6) || (kind == KIND_QUAD8) || (kind == KIND_QPOLY);
  endfunction

  // Kind of a degenerate cell after collapse, chosen by its new node count.
  function automatic logic [KIND_W-1:0] collapsed_kind(input logic [CNT_W-1:0] m,
                                                       input logic quad);
    logic [KIND_W-1:0] k;
    if (quad) begin
      k = (m == NODES_TRI6) ? KIND_TRI6 : (m == NODES_QUAD8) ? KIND_QUAD8 : KIND_QPOLY;
    end else begin
      k = (m == NODES_TRI) ? KIND_TRI : (m == NODES_QUAD) ? KIND_QUAD : KIND_POLY;
    end
    return k;
  endfunction

endpackage

// File: sv/degenerate_polygon_collapse.sv
// Flow: each node of a cell is written to the node store and compared against the stored
// nodes through the store's read port until the first duplicate of the cell is found.
// After the last node, a cell with a duplicate is handed off and scanned, then each kept
// node passes through the emit loop and output register while dropped indices are skipped;
// one cell is in flight at a time.
// Reset (synchronous, active high) clears all control state; the node store has no clear.

module degenerate_polygon_collapse
  import dpc_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [30:0] node_id
  input  logic [KIND_W-1:0]      s_axis_tuser,  // [2:0] cell_kind
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [30:0] out_node, [36:31] count
  output logic [KIND_W-1:0]      m_axis_tuser,  // [2:0] out_kind
  output logic                   m_axis_tlast
);

  localparam int AW = $clog2(MAX_NODES);

  handoff_t          hand;
  col_status_t       col_stat;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [NODE_W-1:0] wr_data;
  logic [AW-1:0]     ld_rd_addr;
  logic [AW-1:0]     col_rd_addr_a;
  logic [AW-1:0]     col_rd_addr_b;
  logic [AW-1:0]     rd_addr_a;
  logic [NODE_W-1:0] rd_data_a;
  logic [NODE_W-1:0] rd_data_b;
  logic [NODE_W-1:0] out_node;
  logic [COUNT_W-1:0] out_count;

  // Node store.
  dpc_ram #(
    .WIDTH(NODE_W),
    .DEPTH(MAX_NODES)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(rd_data_a),
    .rd_addr_b(col_rd_addr_b),
    .rd_data_b(rd_data_b)
  );

  // Port A belongs to the collapse side while it runs, else to the duplicate check.
  assign rd_addr_a = col_stat.active ? col_rd_addr_a : ld_rd_addr;

  dpc_load #(
    .MAX_NODES(MAX_NODES)
  ) u_load (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .node_id  (s_axis_tdata[NODE_W-1:0]),
    .cell_kind(s_axis_tuser),
    .last     (s_axis_tlast),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (ld_rd_addr),
    .rd_data  (rd_data_a),
    .hand     (hand),
    .done     (col_stat.done)
  );

  dpc_collapse #(
    .MAX_NODES(MAX_NODES)
  ) u_collapse (
    .clk      (clk),
    .rst      (rst),
    .hand     (hand),
    .stat     (col_stat),
    .rd_addr_a(col_rd_addr_a),
    .rd_data_a(rd_data_a),
    .rd_addr_b(col_rd_addr_b),
    .rd_data_b(rd_data_b),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_node (out_node),
    .out_kind (m_axis_tuser),
    .out_count(out_count),
    .out_last (m_axis_tlast)
  );

  // Pack the result item.
  assign m_axis_tdata = {(OUT_TDATA_W - NODE_W - COUNT_W)'(0), out_count, out_node};

  // The load side must hold off new items while the store is being collapsed.
  a_no_load_during_collapse: assert property (@(posedge clk) disable iff (rst)
    col_stat.active |-> !s_axis_tready)
    else $error("item accepted while the collapse side owns the node store");

  // A cell is handed over only to an idle collapse side.
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    hand.start |-> !col_stat.active)
    else $error("cell handed over while the collapse side is busy");

  // A handed-over cell always starts a collapse run.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    hand.start |=> col_stat.active)
    else $error("collapse side did not pick up the handed-over cell");

  // Completion returns the collapse side to idle.
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    col_stat.done |=> !col_stat.active)
    else $error("collapse side still active after completion");

endmodule

// File: sv/dpc_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered read data.
// Stand-alone; no package needed.

module dpc_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  output logic [WIDTH-1:0]  rd_data_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: sv/dpc_load.sv
// Load side: accepts the node items of one cell, writes them to the node store and
// checks each new node against the stored ones. Depends on dpc_pkg.

module dpc_load
  import dpc_pkg::*;
#(
  parameter int MAX_NODES = 32,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] node_id,
  input  logic [KIND_W-1:0] cell_kind,
  input  logic              last,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [NODE_W-1:0] wr_data,
  output logic [AW-1:0]     rd_addr,
  input  logic [NODE_W-1:0] rd_data,
  output handoff_t          hand,
  input  logic              done
);

  typedef enum logic [3:0] {
    LD_IDLE  = 4'b0001,
    LD_CHECK = 4'b0010,
    LD_HAND  = 4'b0100,
    LD_WAIT  = 4'b1000
  } ld_state_t;

  ld_state_t         state;
  logic [CW-1:0]     cnt;
  logic [KIND_W-1:0] kind_r;
  logic              dup;
  logic [NODE_W-1:0] cand;
  logic              last_r;
  logic [CW-1:0]     j;
  logic              pend;

  logic accept;
  logic room;
  logic issue;
  logic match;

  // Handshake and store write; nodes past the store depth are dropped.
  assign in_ready = (state == LD_IDLE);
  assign accept   = in_valid && in_ready;
  assign room     = (cnt < CW'(MAX_NODES));
  assign wr_en    = accept && room;
  assign wr_addr  = cnt[AW-1:0];
  assign wr_data  = node_id;

  // Duplicate sweep: the new node sits at cnt-1, so entries 0 to cnt-2 are compared.
  assign issue   = (state == LD_CHECK) && ((j + CW'(1)) < cnt);
  assign rd_addr = j[AW-1:0];
  assign match   = pend && (rd_data == cand);

  // Cell description for the collapse side, valid in the handoff state.
  assign hand.start = (state == LD_HAND);
  assign hand.dup   = dup;
  assign hand.kind  = kind_r;
  assign hand.n     = CNT_W'(cnt);

  // Load sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= LD_IDLE;
      cnt    <= '0;
      kind_r <= '0;
      dup    <= 1'b0;
      last_r <= 1'b0;
      j      <= '0;
      pend   <= 1'b0;
    end else begin
      unique case (state)
        LD_IDLE: begin
          if (accept) begin
            if (cnt == '0) begin
              kind_r <= cell_kind;
            end
            last_r <= last;
            j      <= '0;
            pend   <= 1'b0;
            if (room) begin
              cand <= node_id;
              cnt  <= cnt + CW'(1);
            end
            if (room && (cnt != '0) && !dup) begin
              state <= LD_CHECK;
            end else if (last) begin
              state <= LD_HAND;
            end
          end
        end
        LD_CHECK: begin
          pend <= issue;
          if (issue) begin
            j <= j + CW'(1);
          end
          if (match) begin
            dup <= 1'b1;
          end
          if (match || (!issue && !pend)) begin
            pend  <= 1'b0;
            state <= last_r ? LD_HAND : LD_IDLE;
          end
        end
        LD_HAND: begin
          // The collapse side latches the cell description in this cycle.
          cnt    <= '0;
          kind_r <= '0;
          dup    <= 1'b0;
          state  <= LD_WAIT;
        end
        LD_WAIT: begin
          if (done) begin
            state <= LD_IDLE;
          end
        end
        default: state <= LD_IDLE;
      endcase
    end
  end

endmodule

// File: sv/dpc_collapse.sv
// Collapse side: scans the stored cell, if it has a duplicate, to build the keep mask, then
// emits the kept nodes with the new kind and count through an output register. Depends on dpc_pkg.

module dpc_collapse
  import dpc_pkg::*;
#(
  parameter int MAX_NODES = 32,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  handoff_t          hand,
  output col_status_t       stat,
  output logic [AW-1:0]     rd_addr_a,
  input  logic [NODE_W-1:0] rd_data_a,
  output logic [AW-1:0]     rd_addr_b,
  input  logic [NODE_W-1:0] rd_data_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_node,
  output logic [KIND_W-1:0] out_kind,
  output logic [COUNT_W-1:0] out_count,
  output logic              out_last
);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_SCAN = 6'b000010,
    C_WRAP = 6'b000100,
    C_EMIT = 6'b001000,
    C_LOAD = 6'b010000,
    C_DONE = 6'b100000
  } col_state_t;

  col_state_t           state;
  logic                 quad;
  logic [CW-1:0]        q;
  logic [CW-1:0]        m;
  logic [KIND_W-1:0]    rk;
  logic [MAX_NODES-1:0] keep;
  logic [CW-1:0]        kept;
  logic [CW-1:0]        i;
  logic                 sv;
  logic [CW-1:0]        st;
  logic [NODE_W-1:0]    first;
  logic [NODE_W-1:0]    prev_a;
  logic [NODE_W-1:0]    prev_b;
  logic                 half;
  logic [CW-1:0]        k;

  logic [CW-1:0] nn;
  logic          start_quad;
  logic          issue;
  logic [AW-1:0] st_prev;
  logic          scan_keep;
  logic          wrap_keep;
  logic [CW-1:0] tot;
  logic [CW-1:0] m_new;
  logic [AW-1:0] mid_addr;
  logic          keep_i;
  logic          o_free;
  logic          out_set;

  assign stat.active = (state != C_IDLE);
  assign stat.done   = (state == C_DONE);

  assign nn         = CW'(hand.n);
  assign start_quad = is_quadratic(hand.kind);

  // Read addresses: corner i on port A, its mid node on port B; emit of the second
  // half reads the mid node through port A.
  assign mid_addr  = AW'(i + q);
  assign issue     = (state == C_SCAN) && (i < q);
  assign rd_addr_a = ((state == C_EMIT) && half) ? mid_addr : i[AW-1:0];
  assign rd_addr_b = mid_addr;

  // A corner is kept unless it equals its successor (and, for quadratic cells, its mid).
  assign st_prev   = AW'(st - CW'(1));
  assign scan_keep = (prev_a != rd_data_a) || (quad && (prev_a != prev_b));
  assign wrap_keep = (prev_a != first) || (quad && (prev_a != prev_b));
  assign tot       = kept + CW'(wrap_keep);
  assign m_new     = quad ? CW'(tot << 1) : tot;

  assign keep_i = keep[i[AW-1:0]];
  assign o_free = !out_valid || out_ready;

  // The output register takes a new item in the load state or for an empty cell.
  assign out_set = (state == C_LOAD) || ((state == C_EMIT) && (m == '0) && o_free);

  // Collapse sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      out_valid <= 1'b0;
      sv        <= 1'b0;
      half      <= 1'b0;
      i         <= '0;
      k         <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        C_IDLE: begin
          i    <= '0;
          k    <= '0;
          half <= 1'b0;
          sv   <= 1'b0;
          if (hand.start) begin
            if (hand.dup) begin
              quad  <= start_quad;
              q     <= start_quad ? (nn >> 1) : nn;
              keep  <= '0;
              kept  <= '0;
              state <= C_SCAN;
            end else begin
              // No duplicate: the cell passes unchanged.
              quad  <= 1'b0;
              q     <= nn;
              keep  <= '1;
              m     <= nn;
              rk    <= hand.kind;
              state <= C_EMIT;
            end
          end
        end
        C_SCAN: begin
          sv <= issue;
          st <= i;
          if (issue) begin
            i <= i + CW'(1);
          end
          if (sv) begin
            if (st == '0) begin
              first <= rd_data_a;
            end else begin
              keep[st_prev] <= scan_keep;
              kept          <= kept + CW'(scan_keep);
            end
            prev_a <= rd_data_a;
            prev_b <= rd_data_b;
          end
          if (!issue && !sv) begin
            state <= C_WRAP;
          end
        end
        C_WRAP: begin
          // The last corner closes the cycle against the first one.
          keep[AW'(q - CW'(1))] <= wrap_keep;
          m     <= m_new;
          rk    <= collapsed_kind(CNT_W'(m_new), quad);
          i     <= '0;
          half  <= 1'b0;
          k     <= '0;
          state <= C_EMIT;
        end
        C_EMIT: begin
          if (m == '0) begin
            // Everything collapsed: one empty item.
            if (o_free) begin
              out_node  <= '0;
              out_kind  <= quad ? KIND_QPOLY : KIND_POLY;
              out_count <= '0;
              out_last  <= 1'b1;
              state     <= C_DONE;
            end
          end else if (i == q) begin
            if (quad && !half) begin
              half <= 1'b1;
              i    <= '0;
            end else begin
              state <= C_DONE;
            end
          end else if (!keep_i) begin
            i <= i + CW'(1);
          end else if (o_free) begin
            state <= C_LOAD;
          end
        end
        C_LOAD: begin
          out_node  <= rd_data_a;
          out_kind  <= rk;
          out_count <= COUNT_W'(m);
          out_last  <= ((k + CW'(1)) == m);
          k         <= k + CW'(1);
          i         <= i + CW'(1);
          state     <= C_EMIT;
        end
        C_DONE: begin
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
